### hdl/dlcl_pkg.sv
// Shared codes, widths and reset values for the debounced battery level classifier.
package dlcl_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TIME_W     = 32;
	localparam int RUN_W      = 8;
	localparam int CLASS_W    = 3;
	localparam int KIND_W     = 2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LEVEL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_ENTER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_EXIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD       = 3'd6;

	// Register reset values.
	localparam int RST_FULL_LEVEL = 900;
	localparam int RST_HALF_LEVEL = 700;
	localparam int RST_LOW_LEVEL  = 500;
	localparam int RST_LOCK_ENTER = 450;
	localparam int RST_LOCK_EXIT  = 520;
	localparam logic [RUN_W-1:0] RST_STABLE = 8'd3;
	localparam logic [CFG_DATA_W-1:0] RST_PERIOD = 16'd250;

	// Run counters stop here.
	localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

	// Battery classes.
	localparam logic [CLASS_W-1:0] CLS_UNKNOWN  = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_FULL     = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_HALF     = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_LOW      = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_CRITICAL = 3'd4;

	// Event kinds.
	localparam logic [KIND_W-1:0] EV_CLASS      = 2'd0;
	localparam logic [KIND_W-1:0] EV_LOCK_ENTER = 2'd1;
	localparam logic [KIND_W-1:0] EV_LOCK_EXIT  = 2'd2;

endpackage

### hdl/dlcl_if.sv
// Valid/ready channel interfaces for sample words and event words.
interface dlcl_sample_if #(parameter int ADC_BITS = 10);
	logic                valid;
	logic                ready;
	logic [31:0]         time_ms;
	logic [ADC_BITS-1:0] adc_sample;

	modport source (output valid, output time_ms, output adc_sample, input ready);
	modport sink   (input valid, input time_ms, input adc_sample, output ready);
	modport mon    (input valid, input time_ms, input adc_sample, input ready);
endinterface

interface dlcl_event_if #(parameter int ADC_BITS = 10);
	logic                valid;
	logic                ready;
	logic [1:0]          event_kind;
	logic [2:0]          battery_class;
	logic [ADC_BITS-1:0] adc_value;
	logic [31:0]         event_time;
	logic                last_event;

	modport source (output valid, output event_kind, output battery_class, output adc_value,
		output event_time, output last_event, input ready);
	modport sink   (input valid, input event_kind, input battery_class, input adc_value,
		input event_time, input last_event, output ready);
	modport mon    (input valid, input event_kind, input battery_class, input adc_value,
		input event_time, input last_event, input ready);
endinterface

### hdl/debounced_level_classifier_lockout.sv
// Top level of the debounced battery level classifier with lockout hysteresis.
//
//   channel   direction  word contents
//   samples   in         time_ms, adc_sample
//   events    out        event_kind, battery_class, adc_value, event_time, last_event
//   cfg_*     in         write enable, register index, write data (no read-back)
//
// An accepted sample word lands in the stage-1 register; once the output side has room, its
// state updates are applied and the output register is loaded, and the first event word is
// offered from there. Samples that yield no event or one event flow back to back while the
// output side has room. A sample that yields both a class and a lockout event holds up the
// next due sample: the single output register drains the held lockout word before the next sample
// is processed. Reset clears the control and decision state and restores the register
// defaults. A stall on the event side holds the stage-1 word, and samples that arrive too
// early are dropped without waiting for the output.
module debounced_level_classifier_lockout import dlcl_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dlcl_sample_if.sink           samples,
	dlcl_event_if.source          events,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [ADC_BITS-1:0]   full_level_q, half_level_q, low_level_q;
	logic [ADC_BITS-1:0]   lock_enter_q, lock_exit_q;
	logic [RUN_W-1:0]      stable_q;
	logic [CFG_DATA_W-1:0] period_q;

	// Decision state.
	logic [TIME_W-1:0]  next_time_q;
	logic [CLASS_W-1:0] reported_q, cand_q;
	logic [RUN_W-1:0]   cls_run_q;
	logic               lock_active_q, lock_cand_q;
	logic [RUN_W-1:0]   lock_run_q;

	// Stage 1: the accepted sample word.
	logic                s1_valid_q;
	logic [TIME_W-1:0]   time_s1;
	logic [ADC_BITS-1:0] adc_s1;

	// Output register, plus the kind of a second event waiting behind it.
	logic                out_valid_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [CLASS_W-1:0]  out_class_q;
	logic [ADC_BITS-1:0] out_adc_q;
	logic [TIME_W-1:0]   out_time_q;
	logic                out_last_q;
	logic                pend_valid_q;
	logic [KIND_W-1:0]   pend_kind_q;

	logic               in_fire, out_fire, room, due, s1_take, s1_apply;
	logic [TIME_W-1:0]  time_diff;
	logic [CLASS_W-1:0] want_cls, cand_nxt, reported_nxt;
	logic [RUN_W-1:0]   cls_run_nxt, lock_run_nxt;
	logic               want_lock, lock_cand_nxt, lock_nxt, cls_ev, lock_ev;
	logic [KIND_W-1:0]  lock_kind;

	// The wrap-safe compare: the sample is due when the 32-bit difference is non-negative.
	assign time_diff = time_s1 - next_time_q;
	assign due       = ~time_diff[TIME_W-1];

	// The output side can take new words only when nothing is held back and the
	// output register is empty or being emptied in this cycle.
	assign out_fire = out_valid_q & events.ready;
	assign room     = ~pend_valid_q & (~out_valid_q | events.ready);
	assign s1_take  = s1_valid_q & (~due | room);
	assign s1_apply = s1_take & due;

	assign samples.ready = ~s1_valid_q | s1_take;
	assign in_fire       = samples.valid & samples.ready;

	// Classification against the three thresholds, applied in order full, half, low.
	always_comb begin
		if (adc_s1 >= full_level_q) begin
			want_cls = CLS_FULL;
		end else if (adc_s1 >= half_level_q) begin
			want_cls = CLS_HALF;
		end else if (adc_s1 >= low_level_q) begin
			want_cls = CLS_LOW;
		end else begin
			want_cls = CLS_CRITICAL;
		end
	end

	// Class debounce: a new candidate restarts the run, a repeat extends it up to saturation.
	always_comb begin
		cand_nxt = want_cls;
		if (want_cls != cand_q) begin
			cls_run_nxt = RUN_W'(1);
		end else if (cls_run_q != RUN_MAX) begin
			cls_run_nxt = cls_run_q + RUN_W'(1);
		end else begin
			cls_run_nxt = cls_run_q;
		end
		cls_ev       = (cand_nxt != reported_q) && (cls_run_nxt >= stable_q);
		reported_nxt = cls_ev ? cand_nxt : reported_q;
	end

	// Lockout with hysteresis: the enter level applies while released, the exit level while
	// locked out.
	always_comb begin
		if (lock_active_q) begin
			want_lock = adc_s1 < lock_exit_q;
		end else begin
			want_lock = adc_s1 <= lock_enter_q;
		end
		lock_cand_nxt = want_lock;
		if (want_lock != lock_cand_q) begin
			lock_run_nxt = RUN_W'(1);
		end else if (lock_run_q != RUN_MAX) begin
			lock_run_nxt = lock_run_q + RUN_W'(1);
		end else begin
			lock_run_nxt = lock_run_q;
		end
		lock_ev   = (lock_run_nxt >= stable_q) && (lock_cand_nxt != lock_active_q);
		lock_nxt  = lock_ev ? lock_cand_nxt : lock_active_q;
		lock_kind = lock_nxt ? EV_LOCK_ENTER : EV_LOCK_EXIT;
	end

	// Configuration registers. Writes to an index past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_level_q <= ADC_BITS'(RST_FULL_LEVEL);
			half_level_q <= ADC_BITS'(RST_HALF_LEVEL);
			low_level_q  <= ADC_BITS'(RST_LOW_LEVEL);
			lock_enter_q <= ADC_BITS'(RST_LOCK_ENTER);
			lock_exit_q  <= ADC_BITS'(RST_LOCK_EXIT);
			stable_q     <= RST_STABLE;
			period_q     <= RST_PERIOD;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FULL_LEVEL: full_level_q <= cfg_data[ADC_BITS-1:0];
				REG_HALF_LEVEL: half_level_q <= cfg_data[ADC_BITS-1:0];
				REG_LOW_LEVEL:  low_level_q  <= cfg_data[ADC_BITS-1:0];
				REG_LOCK_ENTER: lock_enter_q <= cfg_data[ADC_BITS-1:0];
				REG_LOCK_EXIT:  lock_exit_q  <= cfg_data[ADC_BITS-1:0];
				REG_STABLE:     stable_q     <= cfg_data[RUN_W-1:0];
				REG_PERIOD:     period_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decision state advances only for a sample that is due.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_time_q   <= '0;
			reported_q    <= CLS_UNKNOWN;
			cand_q        <= CLS_UNKNOWN;
			cls_run_q     <= '0;
			lock_active_q <= 1'b0;
			lock_cand_q   <= 1'b0;
			lock_run_q    <= '0;
		end else if (s1_apply) begin
			next_time_q   <= time_s1 + TIME_W'(period_q);
			reported_q    <= reported_nxt;
			cand_q        <= cand_nxt;
			cls_run_q     <= cls_run_nxt;
			lock_active_q <= lock_nxt;
			lock_cand_q   <= lock_cand_nxt;
			lock_run_q    <= lock_run_nxt;
		end
	end

	// Control flags of stage 1 and the output side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_take) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_apply && (cls_ev || lock_ev)) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= cls_ev & lock_ev;
			end else if (out_fire) begin
				out_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers. When both events fire the class word goes first and only the
	// lockout kind is held; the class, value and time fields are shared by both words.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			time_s1 <= samples.time_ms;
			adc_s1  <= samples.adc_sample;
		end
		if (s1_apply && (cls_ev || lock_ev)) begin
			out_kind_q  <= cls_ev ? EV_CLASS : lock_kind;
			out_class_q <= reported_nxt;
			out_adc_q   <= adc_s1;
			out_time_q  <= time_s1;
			out_last_q  <= ~(cls_ev & lock_ev);
			pend_kind_q <= lock_kind;
		end else if (out_fire && pend_valid_q) begin
			out_kind_q <= pend_kind_q;
			out_last_q <= 1'b1;
		end
	end

	assign events.valid         = out_valid_q;
	assign events.event_kind    = out_kind_q;
	assign events.battery_class = out_class_q;
	assign events.adc_value     = out_adc_q;
	assign events.event_time    = out_time_q;
	assign events.last_event    = out_last_q;

endmodule

### hdl/dlcl_chk.sv
// Port-level checker for the battery level classifier, bound to the top level.
module dlcl_chk import dlcl_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input logic                clk,
	input logic                arst_n,
	input logic                ev_valid,
	input logic                ev_ready,
	input logic [KIND_W-1:0]   ev_kind,
	input logic [CLASS_W-1:0]  ev_class,
	input logic [ADC_BITS-1:0] ev_adc,
	input logic [TIME_W-1:0]   ev_time,
	input logic                ev_last
);

	// A stalled event word stays valid and keeps its kind, time and last flag.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid && $stable(ev_kind)
			&& $stable(ev_time) && $stable(ev_last))
		else $error("event word changed while stalled");

	// Only a class word can be followed by a second word from the same sample.
	a_first_is_class: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_last |-> ev_kind == EV_CLASS)
		else $error("non-final event word is not a class change");

	// The lockout word of the same sample follows right away, with the same sample fields.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_ready && !ev_last |=> ev_valid
			&& ev_last && $stable(ev_time) && $stable(ev_adc)
			&& $stable(ev_class)
			&& (ev_kind == EV_LOCK_ENTER || ev_kind == EV_LOCK_EXIT))
		else $error("second event word of a sample missing or mismatched");

	// A class change never reports the unknown class.
	a_class_known: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_kind == EV_CLASS |-> ev_class != CLS_UNKNOWN)
		else $error("class change event reports unknown class");

endmodule

bind debounced_level_classifier_lockout dlcl_chk #(.ADC_BITS(ADC_BITS)) u_dlcl_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.ev_valid (events.valid),
	.ev_ready (events.ready),
	.ev_kind  (events.event_kind),
	.ev_class (events.battery_class),
	.ev_adc   (events.adc_value),
	.ev_time  (events.event_time),
	.ev_last  (events.last_event)
);

### tb/sv/testbench.sv
// Self-checking testbench for the debounced battery level classifier with lockout.
module testbench;
	import dlcl_pkg::*;

	localparam int ADC_W = 10;

	// Index seven names no register, so a write to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	// Cycles to let pass once the last expected word is in, so that dropped early
	// samples still inside the block have surely left it before a register write.
	localparam int DRAIN = 8;

	// The limit sits well above the slowest correct run: about 500 samples, each with
	// at most two words that may each wait out a ready stall, plus sender gaps.
	localparam int LIMIT = 200000;

	localparam int N_PHASES = 8;
	localparam int N_ROWS   = 25;

	// One event word as the block reports it.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CLASS_W-1:0] cls;
		logic [ADC_W-1:0]   adc;
		logic [TIME_W-1:0]  stamp;
		logic               last;
	} batt_event_t;

	// A row of the directed script: either a register write or a sample word. A sample
	// row with a non-negative count carries its events typed in; otherwise the
	// classifier model below decides them.
	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [TIME_W-1:0]     word;
		logic [ADC_W-1:0]      adc;
		int                    nev;
		batt_event_t           e0;
		batt_event_t           e1;
	} script_row_t;

	localparam batt_event_t NO_EV = '0;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	dlcl_sample_if #(.ADC_BITS(ADC_W)) sample_ch ();
	dlcl_event_if  #(.ADC_BITS(ADC_W)) event_ch ();

	debounced_level_classifier_lockout #(.ADC_BITS(ADC_W)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (sample_ch),
		.events   (event_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Clock: 20 time units per period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Our own copy of the register file, as the block should hold it.
	logic [ADC_W-1:0]      lvl_full, lvl_half, lvl_low, lvl_enter, lvl_exit;
	logic [RUN_W-1:0]      need_run;
	logic [CFG_DATA_W-1:0] period;

	// Our own copy of the classifier state.
	logic [TIME_W-1:0]  due_time;
	logic [CLASS_W-1:0] shown_class, pend_class;
	logic [RUN_W-1:0]   class_run, lock_run;
	logic               locked, pend_lock;

	batt_event_t pending_events[$];

	bit idling;
	int fails;
	int taken_samples, early_samples, events_checked, reg_writes;
	int cycle_cnt;

	// Works out what one sample word does to the classifier and returns the number
	// of event words it causes (zero when the sample arrives before it is due).
	function automatic int classify_sample(input logic [TIME_W-1:0] t,
			input logic [ADC_W-1:0] adc, output batt_event_t ev0, output batt_event_t ev1);
		logic [TIME_W-1:0]  lag;
		logic [CLASS_W-1:0] lvl;
		logic               want_lock;
		batt_event_t        evs [2];
		int                 n;
		n = 0;
		evs[0] = NO_EV;
		evs[1] = NO_EV;
		ev0 = NO_EV;
		ev1 = NO_EV;
		// The due check looks only at the sign of the 32-bit difference, so it
		// keeps working across the wrap of the millisecond counter.
		lag = t - due_time;
		if (lag[TIME_W-1])
			return 0;
		due_time = t + TIME_W'(period);

		// Thresholds are tried in order full, half, low, whatever their values.
		if (adc >= lvl_full)
			lvl = CLS_FULL;
		else if (adc >= lvl_half)
			lvl = CLS_HALF;
		else if (adc >= lvl_low)
			lvl = CLS_LOW;
		else
			lvl = CLS_CRITICAL;

		if (lvl != pend_class) begin
			pend_class = lvl;
			class_run = 8'd1;
		end else if (class_run != RUN_MAX) begin
			class_run = class_run + 8'd1;
		end
		if (pend_class != shown_class && class_run >= need_run) begin
			shown_class = pend_class;
			evs[n] = '{EV_CLASS, shown_class, adc, t, 1'b0};
			n++;
		end

		// Hysteresis: the enter level applies while unlocked, the exit level while
		// locked out.
		want_lock = locked ? (adc < lvl_exit) : (adc <= lvl_enter);
		if (want_lock != pend_lock) begin
			pend_lock = want_lock;
			lock_run = 8'd1;
		end else if (lock_run != RUN_MAX) begin
			lock_run = lock_run + 8'd1;
		end
		if (lock_run >= need_run && pend_lock != locked) begin
			locked = pend_lock;
			evs[n] = '{locked ? EV_LOCK_ENTER : EV_LOCK_EXIT, shown_class, adc, t, 1'b0};
			n++;
		end

		if (n > 0)
			evs[n-1].last = 1'b1;
		ev0 = evs[0];
		ev1 = evs[1];
		return n;
	endfunction

	function automatic batt_event_t ev(input logic [KIND_W-1:0] kind,
			input logic [CLASS_W-1:0] cls, input int adc, input logic [TIME_W-1:0] t,
			input logic last);
		ev = '{kind, cls, ADC_W'(adc), t, last};
	endfunction

	function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
		reg_row = '{1'b1, idx, TIME_W'(data), '0, 0, NO_EV, NO_EV};
	endfunction

	function automatic script_row_t smp_row(input logic [TIME_W-1:0] t, input int adc,
			input int nev, input batt_event_t e0, input batt_event_t e1);
		smp_row = '{1'b0, REG_NONE, t, ADC_W'(adc), nev, e0, e1};
	endfunction

	// Register data with random junk above the used bits, which the block must drop.
	function automatic logic [CFG_DATA_W-1:0] pad10(input int v);
		pad10 = {6'($urandom), 10'(v)};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pad8(input int v);
		pad8 = {8'($urandom), 8'(v)};
	endfunction

	// Parks the sample channel and waits until every expected word is in and the
	// pipeline has had time to empty. Entered and left at a falling edge.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// One register write while the block is idle; the mirror follows at once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
			REG_FULL_LEVEL: lvl_full  = data[ADC_W-1:0];
			REG_HALF_LEVEL: lvl_half  = data[ADC_W-1:0];
			REG_LOW_LEVEL:  lvl_low   = data[ADC_W-1:0];
			REG_LOCK_ENTER: lvl_enter = data[ADC_W-1:0];
			REG_LOCK_EXIT:  lvl_exit  = data[ADC_W-1:0];
			REG_STABLE:     need_run  = data[RUN_W-1:0];
			REG_PERIOD:     period    = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	// Offers one sample word, possibly after a random gap, and records the events it
	// should cause once the block takes it. Entered at a falling edge; returns at the
	// falling edge after the handshake with valid still high, so the caller's next
	// drive either replaces the word or lowers valid.
	task automatic send_sample(input logic [TIME_W-1:0] t, input logic [ADC_W-1:0] adc,
			input int nev, input batt_event_t e0, input batt_event_t e1);
		int          n;
		batt_event_t p0, p1;
		logic [TIME_W-1:0] lag;
		if (idling && $urandom_range(0, 9) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.time_ms    <= t;
		sample_ch.adc_sample <= adc;
		do
			@(posedge clk);
		while (!sample_ch.ready);

		lag = t - due_time;
		if (lag[TIME_W-1])
			early_samples++;
		else
			taken_samples++;
		n = classify_sample(t, adc, p0, p1);
		if (nev >= 0) begin
			n  = nev;
			p0 = e0;
			p1 = e1;
		end
		if (n > 0)
			pending_events.push_back(p0);
		if (n > 1)
			pending_events.push_back(p1);
		@(negedge clk);
	endtask

	// Event side: ready drops in random bursts while idling is on.
	initial begin
		int hold;
		hold = 0;
		event_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				event_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 18) - 1;
				event_ch.ready <= 1'b0;
			end else begin
				event_ch.ready <= 1'b1;
			end
		end
	end

	// Every word taken from the block is held against the oldest expectation.
	always @(posedge clk) begin : check_events
		batt_event_t want;
		if (event_ch.valid && event_ch.ready) begin
			if (pending_events.size() == 0) begin
				$error("event word with none expected: kind %0d class %0d adc %0d time %0d",
					event_ch.event_kind, event_ch.battery_class, event_ch.adc_value,
					event_ch.event_time);
				fails++;
			end else begin
				want = pending_events.pop_front();
				events_checked++;
				if (event_ch.event_kind !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, event_ch.event_kind);
					fails++;
				end
				if (event_ch.battery_class !== want.cls) begin
					$error("battery_class: expected %0d, got %0d", want.cls,
						event_ch.battery_class);
					fails++;
				end
				if (event_ch.adc_value !== want.adc) begin
					$error("adc_value: expected %0d, got %0d", want.adc, event_ch.adc_value);
					fails++;
				end
				if (event_ch.event_time !== want.stamp) begin
					$error("event_time: expected %0h, got %0h", want.stamp, event_ch.event_time);
					fails++;
				end
				if (event_ch.last_event !== want.last) begin
					$error("last_event: expected %0d, got %0d", want.last, event_ch.last_event);
					fails++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		script_row_t           script [N_ROWS];
		logic [CFG_DATA_W-1:0] regv [7];
		logic [TIME_W-1:0]     t;
		int lo, hf, fl, en, ex;
		int base, adc, run_left, items, start;
		bit first_run, steady;

		fails          = 0;
		taken_samples  = 0;
		early_samples  = 0;
		events_checked = 0;
		reg_writes     = 0;
		idling         = 1'b1;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_idx              = REG_FULL_LEVEL;
		cfg_data             = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.time_ms    = '0;
		sample_ch.adc_sample = '0;

		// Register and state values after reset.
		lvl_full    = ADC_W'(RST_FULL_LEVEL);
		lvl_half    = ADC_W'(RST_HALF_LEVEL);
		lvl_low     = ADC_W'(RST_LOW_LEVEL);
		lvl_enter   = ADC_W'(RST_LOCK_ENTER);
		lvl_exit    = ADC_W'(RST_LOCK_EXIT);
		need_run    = RST_STABLE;
		period      = RST_PERIOD;
		due_time    = '0;
		shown_class = CLS_UNKNOWN;
		pend_class  = CLS_UNKNOWN;
		class_run   = '0;
		locked      = 1'b0;
		pend_lock   = 1'b0;
		lock_run    = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed script. With one stable sample needed, each new class or lockout
		// decision is reported on the spot, so most rows can be read straight off.
		// The default thresholds are 900/700/500, lockout 450 in and 520 out, and
		// samples fall due every 250 ms from time zero.
		script = '{
			reg_row(REG_STABLE, 1),
			smp_row(32'd0, 1023, 1, ev(EV_CLASS, CLS_FULL, 1023, 32'd0, 1'b1), NO_EV),
			// Not yet due: dropped without a word.
			smp_row(32'd100, 0, 0, NO_EV, NO_EV),
			// Class and lockout change on one sample: the class word comes first.
			smp_row(32'd250, 0, 2, ev(EV_CLASS, CLS_CRITICAL, 0, 32'd250, 1'b0),
				ev(EV_LOCK_ENTER, CLS_CRITICAL, 0, 32'd250, 1'b1)),
			// Just below the exit level: still locked out.
			smp_row(32'd500, 519, 1, ev(EV_CLASS, CLS_LOW, 519, 32'd500, 1'b1), NO_EV),
			smp_row(32'd750, 520, 1, ev(EV_LOCK_EXIT, CLS_LOW, 520, 32'd750, 1'b1), NO_EV),
			smp_row(32'd1000, 899, 1, ev(EV_CLASS, CLS_HALF, 899, 32'd1000, 1'b1), NO_EV),
			smp_row(32'd1250, 900, 1, ev(EV_CLASS, CLS_FULL, 900, 32'd1250, 1'b1), NO_EV),
			smp_row(32'd1500, 450, 2, ev(EV_CLASS, CLS_CRITICAL, 450, 32'd1500, 1'b0),
				ev(EV_LOCK_ENTER, CLS_CRITICAL, 450, 32'd1500, 1'b1)),
			// Far behind the due time in signed terms: dropped.
			smp_row(32'hFFFF_FF00, 1023, 0, NO_EV, NO_EV),
			// Just under half the time range ahead still counts as due.
			smp_row(32'h8000_06D5, 450, 0, NO_EV, NO_EV),
			// The next due time wraps past zero to 249.
			smp_row(32'hFFFF_FFFF, 1023, 2, ev(EV_CLASS, CLS_FULL, 1023, 32'hFFFF_FFFF, 1'b0),
				ev(EV_LOCK_EXIT, CLS_FULL, 1023, 32'hFFFF_FFFF, 1'b1)),
			smp_row(32'd0, 700, 0, NO_EV, NO_EV),
			smp_row(32'd249, 700, 1, ev(EV_CLASS, CLS_HALF, 700, 32'd249, 1'b1), NO_EV),
			// A zero period accepts every sample at or after the last one's time.
			reg_row(REG_PERIOD, 0),
			smp_row(32'd499, 500, 1, ev(EV_CLASS, CLS_LOW, 500, 32'd499, 1'b1), NO_EV),
			smp_row(32'd498, 0, 0, NO_EV, NO_EV),
			// A write past the last register must leave everything alone.
			reg_row(REG_NONE, 16'hFFFF),
			// Zero stable samples behaves like one.
			reg_row(REG_STABLE, 0),
			smp_row(32'd499, 1023, 1, ev(EV_CLASS, CLS_FULL, 1023, 32'd499, 1'b1), NO_EV),
			// Back to a real debounce of three: left to the model.
			reg_row(REG_STABLE, 3),
			smp_row(32'd499, 0, -1, NO_EV, NO_EV),
			smp_row(32'd499, 0, -1, NO_EV, NO_EV),
			smp_row(32'd499, 0, -1, NO_EV, NO_EV),
			smp_row(32'd499, 1023, -1, NO_EV, NO_EV)
		};

		foreach (script[i]) begin
			if (script[i].is_reg)
				write_reg(script[i].idx, script[i].word[CFG_DATA_W-1:0]);
			else
				send_sample(script[i].word, script[i].adc, script[i].nev, script[i].e0,
					script[i].e1);
		end

		// Random phases, each under its own register setting. Samples come in runs
		// around a threshold so that the debounce and the hysteresis actually settle
		// and change; a few are sent early or with big time jumps as noise. A long
		// first run under a long debounce is kept clean and on time, so that the run
		// counters really climb all the way.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph == N_PHASES - 1)
				idling = 1'b0;
			lo = $urandom_range(0, 1023);
			hf = $urandom_range(lo, 1023);
			fl = $urandom_range(hf, 1023);
			en = $urandom_range(0, 1023);
			ex = $urandom_range(en, 1023);
			case (ph)
				// Extremes: nothing is critical, lockout needs a zero reading and a
				// full-scale one to leave, and the period is zero.
				0: regv = '{pad10(1023), pad10(512), pad10(0), pad10(0), pad10(1023),
					pad8(1), 16'd0};
				// Everything is full, the enter level sits above the exit level so
				// the lockout toggles, and the longest period.
				1: regv = '{pad10(0), pad10(0), pad10(0), pad10(1023), pad10(0),
					pad8(0), 16'hFFFF};
				// Thresholds in no particular order.
				5: regv = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), pad8(2), 16'($urandom)};
				// The longest debounce, where the run counters reach saturation.
				6: regv = '{pad10(RST_FULL_LEVEL), pad10(RST_HALF_LEVEL), pad10(RST_LOW_LEVEL),
					pad10(RST_LOCK_ENTER), pad10(RST_LOCK_EXIT), pad8(255), 16'd1};
				default: regv = '{pad10(fl), pad10(hf), pad10(lo), pad10(en), pad10(ex),
					pad8($urandom_range(1, 6)), 16'($urandom_range(1, 1000))};
			endcase
			for (int r = 0; r < 7; r++)
				write_reg(CFG_IDX_W'(r), regv[r]);
			if (ph == 5)
				write_reg(REG_NONE, 16'($urandom));

			items     = (ph == 6) ? 270 : 25;
			start     = taken_samples;
			run_left  = 0;
			base      = 0;
			first_run = 1'b1;
			steady    = 1'b0;
			while (taken_samples - start < items) begin
				if (run_left == 0) begin
					case ($urandom_range(0, 5))
						0: base = int'(lvl_full) + int'($urandom_range(0, 4)) - 2;
						1: base = int'(lvl_half) + int'($urandom_range(0, 4)) - 2;
						2: base = int'(lvl_low) + int'($urandom_range(0, 4)) - 2;
						3: base = ($urandom_range(0, 1) ? int'(lvl_enter) : int'(lvl_exit))
							+ int'($urandom_range(0, 4)) - 2;
						4: base = $urandom_range(0, 1) ? 1023 : 0;
						default: base = $urandom_range(0, 1023);
					endcase
					steady = first_run && need_run > 8'd16;
					if (steady)
						run_left = int'(need_run) + $urandom_range(1, 4);
					else
						run_left = $urandom_range(1, int'(need_run) + 3);
					first_run = 1'b0;
				end
				run_left--;
				adc = base;
				if (!steady && $urandom_range(0, 4) == 0)
					adc = adc + int'($urandom_range(0, 2)) - 1;
				if (adc < 0)
					adc = 0;
				if (adc > 1023)
					adc = 1023;

				if (steady) begin
					t = due_time + TIME_W'($urandom_range(0, 3));
				end else begin
					case ($urandom_range(0, 19))
						0: t = $urandom;
						1, 2: t = due_time - TIME_W'($urandom_range(1, 1000));
						3: t = due_time + TIME_W'($urandom_range(0, 32'h7FFF_FFFF));
						default: t = due_time + TIME_W'($urandom_range(0, 3));
					endcase
				end
				send_sample(t, ADC_W'(adc), -1, NO_EV, NO_EV);
			end
		end

		settle();

		$display("Covered %0d due samples and %0d early ones over %0d register writes;",
			taken_samples, early_samples, reg_writes);
		$display("%0d event words checked, %0d mismatches.", events_checked, fails);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
